// ----- design/dci_pkg.sv -----
// Shared types, codes and constants for the discount curve interpolator.
// Used by the controller, the datapath and the top level; depends on nothing.
package dci_pkg;

	localparam int DEFAULT_NUM_KNOTS = 32;
	localparam int LOG_FRAC          = 26;
	localparam int DIV_STEPS         = 63;

	localparam logic [1:0] MODE_LINEAR     = 2'd0;
	localparam logic [1:0] MODE_LOG_LINEAR = 2'd1;
	localparam logic [1:0] MODE_FLAT_FWD   = 2'd2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [2:0] STAT_OK          = 3'd0;
	localparam logic [2:0] STAT_EMPTY       = 3'd1;
	localparam logic [2:0] STAT_ZERO_FACTOR = 3'd2;
	localparam logic [2:0] STAT_ZERO_WIDTH  = 3'd3;
	localparam logic [2:0] STAT_SATURATED   = 3'd4;

	localparam logic [2:0] ADDR_MODE  = 3'd0;
	localparam logic [2:0] ADDR_COUNT = 3'd4;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHK0, ST_CHKL, ST_PEN, ST_SRCH, ST_CMP, ST_RDI, ST_RDI2,
		ST_INTV, ST_DIV, ST_MODE, ST_LIN, ST_LOG1, ST_LOGF1, ST_LOG2, ST_LOGF2,
		ST_MV1, ST_MV2, ST_MV3, ST_EXP, ST_EXPF, ST_OUT
	} dci_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_START, OP_RES_EMPTY, OP_RES_RD, OP_RDLAST, OP_RDPEN,
		OP_SINIT, OP_PROBE, OP_CMP, OP_IDX, OP_LATCH1, OP_LATCH2, OP_RES_ZW,
		OP_WONE, OP_DIVINIT, OP_DIV, OP_LINMUL, OP_LINRES, OP_RES_ZF, OP_LOGINIT1,
		OP_LOGSTEP, OP_LOGFIN1, OP_LOGFIN2, OP_MV1, OP_MV2, OP_MV3, OP_EXPSTEP,
		OP_EXPRES, OP_PUSH
	} dci_op_t;

	typedef struct packed {
		dci_op_t op;
	} dci_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic n_one;
		logic rd_lt_t;
		logic rd_eq_t;
		logic is_log;
		logic is_ffwd;
		logic cnt_zero;
		logic zero_width;
		logic num_ge_den;
		logic zero_factor;
		logic extrap;
		logic div_last;
		logic step_last;
	} dci_status_t;

	typedef logic [31:0] dci_root_tab_t [LOG_FRAC];

	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] x;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		x = v;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Successive square roots of 2.0 in Q1.31, i.e. 2^(2^-k) for k = 1..LOG_FRAC.
	function automatic dci_root_tab_t exp_roots();
		logic [63:0]   r;
		dci_root_tab_t tab;
		r = 64'h1_0000_0000;
		for (int k = 0; k < LOG_FRAC; k++) begin
			r = isqrt64(r << 31);
			tab[k] = r[31:0];
		end
		return tab;
	endfunction

	localparam dci_root_tab_t EXP_ROOT = exp_roots();

endpackage

// ----- design/dci_ctrl.sv -----
// Sequencing state machine of the discount curve interpolator.
// Depends on dci_pkg; drives the datapath through dci_cmd_t and reads dci_status_t.
module dci_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_cmd,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  dci_pkg::dci_status_t status,
	output dci_pkg::dci_cmd_t    cmd
);

	dci_pkg::dci_state_t state_q, state_nx;
	logic                out_valid_q;
	logic                out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == dci_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dci_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.op == dci_pkg::OP_PUSH) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			dci_pkg::ST_IDLE: begin
				if (in_valid && in_cmd == dci_pkg::CMD_QUERY) state_nx = dci_pkg::ST_CHK0;
			end
			dci_pkg::ST_CHK0: begin
				priority if (status.n_zero) state_nx = dci_pkg::ST_OUT;
				else if (status.n_one || !status.rd_lt_t) state_nx = dci_pkg::ST_OUT;
				else state_nx = dci_pkg::ST_CHKL;
			end
			dci_pkg::ST_CHKL: begin
				priority if (status.rd_lt_t || status.rd_eq_t) begin
					if (!status.is_ffwd || status.rd_eq_t) state_nx = dci_pkg::ST_OUT;
					else state_nx = dci_pkg::ST_PEN;
				end else state_nx = dci_pkg::ST_SRCH;
			end
			dci_pkg::ST_PEN:  state_nx = dci_pkg::ST_INTV;
			dci_pkg::ST_SRCH: state_nx = status.cnt_zero ? dci_pkg::ST_RDI : dci_pkg::ST_CMP;
			dci_pkg::ST_CMP:  state_nx = dci_pkg::ST_SRCH;
			dci_pkg::ST_RDI:  state_nx = dci_pkg::ST_RDI2;
			dci_pkg::ST_RDI2: state_nx = dci_pkg::ST_INTV;
			dci_pkg::ST_INTV: begin
				priority if (status.zero_width) state_nx = dci_pkg::ST_OUT;
				else if (!status.extrap && status.num_ge_den) state_nx = dci_pkg::ST_MODE;
				else state_nx = dci_pkg::ST_DIV;
			end
			dci_pkg::ST_DIV: begin
				if (status.div_last) state_nx = dci_pkg::ST_MODE;
			end
			dci_pkg::ST_MODE: begin
				priority if (!status.is_log) state_nx = dci_pkg::ST_LIN;
				else if (status.zero_factor) state_nx = dci_pkg::ST_OUT;
				else state_nx = dci_pkg::ST_LOG1;
			end
			dci_pkg::ST_LIN:   state_nx = dci_pkg::ST_OUT;
			dci_pkg::ST_LOG1:  if (status.step_last) state_nx = dci_pkg::ST_LOGF1;
			dci_pkg::ST_LOGF1: state_nx = dci_pkg::ST_LOG2;
			dci_pkg::ST_LOG2:  if (status.step_last) state_nx = dci_pkg::ST_LOGF2;
			dci_pkg::ST_LOGF2: state_nx = dci_pkg::ST_MV1;
			dci_pkg::ST_MV1:   state_nx = dci_pkg::ST_MV2;
			dci_pkg::ST_MV2:   state_nx = dci_pkg::ST_MV3;
			dci_pkg::ST_MV3:   state_nx = dci_pkg::ST_EXP;
			dci_pkg::ST_EXP:   if (status.step_last) state_nx = dci_pkg::ST_EXPF;
			dci_pkg::ST_EXPF:  state_nx = dci_pkg::ST_OUT;
			dci_pkg::ST_OUT:   if (out_free) state_nx = dci_pkg::ST_IDLE;
			default:           state_nx = dci_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = dci_pkg::OP_NONE;
		unique case (state_q)
			dci_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.op = (in_cmd == dci_pkg::CMD_QUERY) ? dci_pkg::OP_START
						: dci_pkg::OP_LOAD;
				end
			end
			dci_pkg::ST_CHK0: begin
				priority if (status.n_zero) cmd.op = dci_pkg::OP_RES_EMPTY;
				else if (status.n_one || !status.rd_lt_t) cmd.op = dci_pkg::OP_RES_RD;
				else cmd.op = dci_pkg::OP_RDLAST;
			end
			dci_pkg::ST_CHKL: begin
				priority if (status.rd_lt_t || status.rd_eq_t) begin
					if (!status.is_ffwd || status.rd_eq_t) cmd.op = dci_pkg::OP_RES_RD;
					else cmd.op = dci_pkg::OP_RDPEN;
				end else cmd.op = dci_pkg::OP_SINIT;
			end
			dci_pkg::ST_PEN:  cmd.op = dci_pkg::OP_LATCH1;
			dci_pkg::ST_SRCH: cmd.op = status.cnt_zero ? dci_pkg::OP_IDX : dci_pkg::OP_PROBE;
			dci_pkg::ST_CMP:  cmd.op = dci_pkg::OP_CMP;
			dci_pkg::ST_RDI:  cmd.op = dci_pkg::OP_LATCH1;
			dci_pkg::ST_RDI2: cmd.op = dci_pkg::OP_LATCH2;
			dci_pkg::ST_INTV: begin
				priority if (status.zero_width) cmd.op = dci_pkg::OP_RES_ZW;
				else if (!status.extrap && status.num_ge_den) cmd.op = dci_pkg::OP_WONE;
				else cmd.op = dci_pkg::OP_DIVINIT;
			end
			dci_pkg::ST_DIV: cmd.op = dci_pkg::OP_DIV;
			dci_pkg::ST_MODE: begin
				priority if (!status.is_log) cmd.op = dci_pkg::OP_LINMUL;
				else if (status.zero_factor) cmd.op = dci_pkg::OP_RES_ZF;
				else cmd.op = dci_pkg::OP_LOGINIT1;
			end
			dci_pkg::ST_LIN:   cmd.op = dci_pkg::OP_LINRES;
			dci_pkg::ST_LOG1:  cmd.op = dci_pkg::OP_LOGSTEP;
			dci_pkg::ST_LOGF1: cmd.op = dci_pkg::OP_LOGFIN1;
			dci_pkg::ST_LOG2:  cmd.op = dci_pkg::OP_LOGSTEP;
			dci_pkg::ST_LOGF2: cmd.op = dci_pkg::OP_LOGFIN2;
			dci_pkg::ST_MV1:   cmd.op = dci_pkg::OP_MV1;
			dci_pkg::ST_MV2:   cmd.op = dci_pkg::OP_MV2;
			dci_pkg::ST_MV3:   cmd.op = dci_pkg::OP_MV3;
			dci_pkg::ST_EXP:   cmd.op = dci_pkg::OP_EXPSTEP;
			dci_pkg::ST_EXPF:  cmd.op = dci_pkg::OP_EXPRES;
			dci_pkg::ST_OUT:   if (out_free) cmd.op = dci_pkg::OP_PUSH;
			default:           cmd.op = dci_pkg::OP_NONE;
		endcase
	end

endmodule

// ----- design/dci_datapath.sv -----
// Datapath of the discount curve interpolator: knot memory, search registers,
// serial divider, shared multiplier, log2/exp2 iterations. Depends on dci_pkg.
module dci_datapath #(
	parameter int NUM_KNOTS = dci_pkg::DEFAULT_NUM_KNOTS
) (
	input  logic                 clk,
	input  dci_pkg::dci_cmd_t    cmd,
	output dci_pkg::dci_status_t status,
	input  logic [1:0]           mode,
	input  logic [5:0]           knot_count,
	input  logic [4:0]           knot_index,
	input  logic [31:0]          time_point,
	input  logic [31:0]          knot_factor,
	output logic [31:0]          factor,
	output logic [2:0]           result_status
);

	localparam int AW  = $clog2(NUM_KNOTS);
	localparam int CW0 = $clog2(NUM_KNOTS + 1);
	localparam int CW  = (CW0 > 6) ? CW0 : 6;
	localparam int LF  = dci_pkg::LOG_FRAC;

	logic [63:0] knot_mem [NUM_KNOTS];
	logic [63:0] rd_q;

	logic [31:0] t_q, t1_q, t2_q, f1_q, f2_q, den_q;
	logic [CW-1:0] lo_q, cnt_q;
	logic [AW-1:0] k_q;
	logic        extrap_q;
	logic [32:0] rem_q;
	logic [62:0] dq_q;
	logic [31:0] m_q;
	logic [LF-1:0] frac_q;
	logic [4:0]  p_q;
	logic [5:0]  it_q;
	logic signed [31:0] l1_q, l2_q;
	logic [63:0] p1_q, prod_q;
	logic signed [41:0] lv_q;
	logic [31:0] res_f_q, out_f_q;
	logic [2:0]  res_s_q, out_s_q;

	logic [CW-1:0] n, nm1, nm2, step, probe, lo_dec, idx_sel, idx_ext;
	logic [AW-1:0] rd_addr;
	logic          rd_en;
	logic [31:0]   rd_time, rd_fac, num, den, absdiff;
	logic [31:0]   mul_a, mul_b;
	logic [63:0]   mul_p;
	logic [32:0]   rr, sq_hi;
	logic          div_ge;
	logic [31:0]   norm_src, norm_m;
	logic [4:0]    lead_p;
	logic signed [31:0] lexp, lv;
	logic signed [32:0] d;
	logic [31:0]   ad;
	logic [63:0]   q_sum;
	logic [40:0]   q_cap;
	logic signed [41:0] base, lv_new;
	logic [LF-1:0] fr;
	logic signed [15:0] ip, sh;
	logic [31:0]   exp_f;
	logic [2:0]    exp_s;

	assign rd_time = rd_q[31:0];
	assign rd_fac  = rd_q[63:32];

	always_comb begin
		n       = (CW'(knot_count) > CW'(NUM_KNOTS)) ? CW'(NUM_KNOTS) : CW'(knot_count);
		nm1     = n - CW'(1);
		nm2     = n - CW'(2);
		step    = cnt_q >> 1;
		probe   = lo_q + step;
		lo_dec  = (lo_q != '0) ? lo_q - CW'(1) : '0;
		idx_sel = (lo_dec > nm2) ? nm2 : lo_dec;
		idx_ext = CW'(knot_index);
	end

	always_comb begin
		rd_en   = 1'b1;
		rd_addr = '0;
		unique case (cmd.op)
			dci_pkg::OP_START:  rd_addr = '0;
			dci_pkg::OP_RDLAST: rd_addr = nm1[AW-1:0];
			dci_pkg::OP_RDPEN:  rd_addr = nm2[AW-1:0];
			dci_pkg::OP_PROBE:  rd_addr = probe[AW-1:0];
			dci_pkg::OP_IDX:    rd_addr = idx_sel[AW-1:0];
			dci_pkg::OP_LATCH1: rd_addr = k_q + AW'(1);
			default:            rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == dci_pkg::OP_LOAD && idx_ext < CW'(NUM_KNOTS))
			knot_mem[idx_ext[AW-1:0]] <= {knot_factor, time_point};
		if (rd_en) rd_q <= knot_mem[rd_addr];
	end

	// Interval quantities.
	always_comb begin
		den = t2_q - t1_q;
		if (extrap_q) num = t_q - t2_q;
		else num = (t_q > t1_q) ? t_q - t1_q : '0;
		absdiff = (f2_q >= f1_q) ? f2_q - f1_q : f1_q - f2_q;
		rr      = {rem_q[31:0], dq_q[62]};
		div_ge  = rr >= {1'b0, den_q};
	end

	// Leading-one normalisation for the log2 unit.
	always_comb begin
		norm_src = (cmd.op == dci_pkg::OP_LOGFIN1) ? f2_q : f1_q;
		lead_p   = '0;
		for (int j = 0; j < 32; j++) begin
			if (norm_src[j]) lead_p = 5'(j);
		end
		norm_m = norm_src << (5'd31 - lead_p);
	end

	always_comb begin
		lexp = $signed({27'd0, p_q}) - 32'sd30;
		lv   = (lexp <<< LF) + $signed({6'd0, frac_q});
		d    = $signed({l2_q[31], l2_q}) - $signed({l1_q[31], l1_q});
		ad   = d[32] ? 32'(-d) : d[31:0];
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			dci_pkg::OP_LINMUL: begin
				mul_a = absdiff;
				mul_b = dq_q[31:0];
			end
			dci_pkg::OP_MV1: begin
				mul_a = ad;
				mul_b = dq_q[62:31];
			end
			dci_pkg::OP_MV2: begin
				mul_a = ad;
				mul_b = {1'b0, dq_q[30:0]};
			end
			dci_pkg::OP_LOGSTEP: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			dci_pkg::OP_EXPSTEP: begin
				mul_a = m_q;
				mul_b = dci_pkg::EXP_ROOT[it_q[4:0]];
			end
			default: ;
		endcase
		mul_p = mul_a * mul_b;
		sq_hi = mul_p[63:31];
	end

	// Log-domain move with the magnitude capped at 2^40.
	always_comb begin
		q_sum  = p1_q + {31'd0, prod_q[63:31]};
		q_cap  = (q_sum > 64'h100_0000_0000) ? 41'h100_0000_0000 : q_sum[40:0];
		base   = extrap_q ? 42'(l2_q) : 42'(l1_q);
		lv_new = d[32] ? base - $signed({1'b0, q_cap}) : base + $signed({1'b0, q_cap});
	end

	// Final scaling of the exp2 mantissa to Q2.30.
	always_comb begin
		fr = lv_q[LF-1:0];
		ip = lv_q[41:LF];
		sh = 16'sd1 - ip;
		exp_s = dci_pkg::STAT_OK;
		priority if (ip > 16'sd1) begin
			exp_f = 32'hFFFF_FFFF;
			exp_s = dci_pkg::STAT_SATURATED;
		end else if (ip == 16'sd1) exp_f = m_q;
		else if (ip < -16'sd30) exp_f = '0;
		else exp_f = m_q >> sh[4:0];
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			dci_pkg::OP_START: t_q <= time_point;
			dci_pkg::OP_RES_EMPTY: begin
				res_f_q <= '0;
				res_s_q <= dci_pkg::STAT_EMPTY;
			end
			dci_pkg::OP_RES_RD: begin
				res_f_q <= rd_fac;
				res_s_q <= dci_pkg::STAT_OK;
			end
			dci_pkg::OP_RDPEN: begin
				t2_q     <= rd_time;
				f2_q     <= rd_fac;
				extrap_q <= 1'b1;
			end
			dci_pkg::OP_SINIT: begin
				lo_q     <= '0;
				cnt_q    <= n;
				extrap_q <= 1'b0;
			end
			dci_pkg::OP_CMP: begin
				if (rd_time < t_q) begin
					lo_q  <= probe + CW'(1);
					cnt_q <= cnt_q - step - CW'(1);
				end else begin
					cnt_q <= step;
				end
			end
			dci_pkg::OP_IDX: k_q <= idx_sel[AW-1:0];
			dci_pkg::OP_LATCH1: begin
				t1_q <= rd_time;
				f1_q <= rd_fac;
			end
			dci_pkg::OP_LATCH2: begin
				t2_q <= rd_time;
				f2_q <= rd_fac;
			end
			dci_pkg::OP_RES_ZW: begin
				res_f_q <= extrap_q ? f2_q : f1_q;
				res_s_q <= dci_pkg::STAT_ZERO_WIDTH;
			end
			dci_pkg::OP_WONE: dq_q <= 63'h8000_0000;
			dci_pkg::OP_DIVINIT: begin
				rem_q <= '0;
				dq_q  <= {num, 31'd0};
				den_q <= den;
				it_q  <= '0;
			end
			dci_pkg::OP_DIV: begin
				rem_q <= div_ge ? rr - {1'b0, den_q} : rr;
				dq_q  <= {dq_q[61:0], div_ge};
				it_q  <= it_q + 6'd1;
			end
			dci_pkg::OP_LINMUL: prod_q <= mul_p;
			dci_pkg::OP_LINRES: begin
				res_f_q <= (f2_q >= f1_q) ? f1_q + prod_q[62:31] : f1_q - prod_q[62:31];
				res_s_q <= dci_pkg::STAT_OK;
			end
			dci_pkg::OP_RES_ZF: begin
				res_f_q <= '0;
				res_s_q <= dci_pkg::STAT_ZERO_FACTOR;
			end
			dci_pkg::OP_LOGINIT1: begin
				m_q    <= norm_m;
				p_q    <= lead_p;
				frac_q <= '0;
				it_q   <= '0;
			end
			dci_pkg::OP_LOGSTEP: begin
				if (sq_hi[32]) begin
					m_q    <= sq_hi[32:1];
					frac_q <= {frac_q[LF-2:0], 1'b1};
				end else begin
					m_q    <= sq_hi[31:0];
					frac_q <= {frac_q[LF-2:0], 1'b0};
				end
				it_q <= it_q + 6'd1;
			end
			dci_pkg::OP_LOGFIN1: begin
				l1_q   <= lv;
				m_q    <= norm_m;
				p_q    <= lead_p;
				frac_q <= '0;
				it_q   <= '0;
			end
			dci_pkg::OP_LOGFIN2: l2_q <= lv;
			dci_pkg::OP_MV1: p1_q <= mul_p;
			dci_pkg::OP_MV2: prod_q <= mul_p;
			dci_pkg::OP_MV3: begin
				lv_q <= lv_new;
				m_q  <= 32'h8000_0000;
				it_q <= '0;
			end
			dci_pkg::OP_EXPSTEP: begin
				if (fr[5'(LF - 1) - it_q[4:0]]) m_q <= mul_p[62:31];
				it_q <= it_q + 6'd1;
			end
			dci_pkg::OP_EXPRES: begin
				res_f_q <= exp_f;
				res_s_q <= exp_s;
			end
			dci_pkg::OP_PUSH: begin
				out_f_q <= res_f_q;
				out_s_q <= res_s_q;
			end
			default: ;
		endcase
	end

	assign factor        = out_f_q;
	assign result_status = out_s_q;

	always_comb begin
		status.n_zero      = (n == '0);
		status.n_one       = (n == CW'(1));
		status.rd_lt_t     = rd_time < t_q;
		status.rd_eq_t     = rd_time == t_q;
		status.is_log      = (mode == dci_pkg::MODE_LOG_LINEAR) ||
			(mode == dci_pkg::MODE_FLAT_FWD);
		status.is_ffwd     = (mode == dci_pkg::MODE_FLAT_FWD);
		status.cnt_zero    = (cnt_q == '0);
		status.zero_width  = t2_q <= t1_q;
		status.num_ge_den  = num >= den;
		status.zero_factor = (f1_q == '0) || (f2_q == '0);
		status.extrap      = extrap_q;
		status.div_last    = (it_q == 6'(dci_pkg::DIV_STEPS - 1));
		status.step_last   = (it_q == 6'(LF - 1));
	end

endmodule

// ----- design/discount_curve_interpolator_core.sv -----
// Discount curve interpolator: a knot load is written from the idle state and the next request is
// taken at once. A query holds the input until its result has entered the output register,
// including any wait for the result side. It may run the 63-step serial divider, and in the log
// modes the two 26-step log2 passes and the 26-step exp2 pass on the one shared multiplier.
// Reset (arst_n low) clears the mode and knot count registers, the state machine and the output
// valid; the knot memory is not cleared and holds nothing meaningful until loaded.
module discount_curve_interpolator_core #(
	parameter int NUM_KNOTS = dci_pkg::DEFAULT_NUM_KNOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // knot_index[4:0], time_point[36:5], knot_factor[68:37], zeros
	input  logic        s_tuser,  // cmd: 0 load a knot, 1 query
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // factor[31:0]
	output logic [2:0]  m_tuser,  // status[2:0]
	// Register port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [1:0] mode_q;
	logic [5:0] count_q;

	dci_pkg::dci_cmd_t    cmd;
	dci_pkg::dci_status_t status;

	// The register port never stalls. Address 0 holds the mode; every other address
	// reaches the knot count register, whose documented address is 4.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= dci_pkg::MODE_LINEAR;
			count_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr == dci_pkg::ADDR_MODE) mode_q <= pwdata[1:0];
			else count_q <= pwdata[5:0];
		end
	end

	assign prdata = (paddr == dci_pkg::ADDR_MODE) ? {30'd0, mode_q} : {26'd0, count_q};

	// The controller walks each query through the clamp checks, the binary search
	// over the knot memory, the weight division and either the linear blend or the
	// log2 / blend / exp2 sequence, then parks the result in the output register.
	dci_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_cmd    (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath owns the knot memory and all working registers; the output
	// register lives there too, so a new request may enter while a result waits.
	dci_datapath #(
		.NUM_KNOTS (NUM_KNOTS)
	) u_datapath (
		.clk           (clk),
		.cmd           (cmd),
		.status        (status),
		.mode          (mode_q),
		.knot_count    (count_q),
		.knot_index    (s_tdata[4:0]),
		.time_point    (s_tdata[36:5]),
		.knot_factor   (s_tdata[68:37]),
		.factor        (m_tdata),
		.result_status (m_tuser)
	);

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for discount_curve_interpolator_core: directed and random knot loads
// and curve queries, checked against a bit-accurate predictor. Depends on dci_pkg and the core.
module tb;

	localparam int KNOTS       = 32;
	localparam int LOG_BITS    = 26;
	localparam int SETTLE      = 400;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [31:0] factor;
		logic [2:0]  status;
	} curve_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;  // knot_index[4:0], time_point[36:5], knot_factor[68:37], zeros
	logic        s_tuser = 1'b0; // cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;  // factor[31:0]
	logic [2:0]  m_tuser;  // status[2:0]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Predictor copy of the curve table and registers.
	logic [31:0]   knot_time [KNOTS];
	logic [31:0]   knot_fac [KNOTS];
	logic [1:0]    curve_mode;
	logic [5:0]    curve_count;
	logic [63:0]   exp_root [LOG_BITS];
	curve_result_t pending_factors[$];
	int            errors = 0;
	int            cycles = 0;
	int            sent = 0;
	bit            no_idle = 0;
	bit            hold_req = 0;

	discount_curve_interpolator_core dut (.*);

	always #5 clk = ~clk;

	// The run is ended by force if it takes far longer than the slowest correct run would.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// log2 of a Q2.30 value, 26 fraction bits: integer part from the leading one, fraction by
	// repeated squaring of the normalised mantissa.
	function automatic longint log2_q(logic [31:0] x);
		int          p;
		logic [63:0] m;
		longint      frac;
		p = 31;
		frac = 0;
		while (p > 0 && !x[p]) p--;
		m = 64'(x) << (31 - p);
		for (int k = 0; k < LOG_BITS; k++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return longint'(p - 30) * (longint'(1) << LOG_BITS) + frac;
	endfunction

	function automatic logic [31:0] exp2_q(longint l, output bit sat);
		longint      ip;
		longint      s;
		logic [63:0] fr;
		logic [63:0] m;
		m = 64'h8000_0000;
		if (l >= 0) ip = l >>> LOG_BITS;
		else ip = -longint'((64'(-l) + ((64'd1 << LOG_BITS) - 1)) >> LOG_BITS);
		fr = 64'(l - ip * (longint'(1) << LOG_BITS));
		for (int k = 1; k <= LOG_BITS; k++)
			if (fr[LOG_BITS - k]) m = (m * exp_root[k - 1]) >> 31;
		sat = 0;
		s = ip - 1;
		if (s >= 1) begin
			sat = 1;
			return 32'hFFFF_FFFF;
		end
		if (s == 0) return m[31:0];
		if (-s >= 32) return 32'd0;
		return 32'(m >> (-s));
	endfunction

	// Moves a log value by the log difference scaled by a Q1.31 weight, capped at 2^40.
	function automatic longint log_step(longint base, longint hi, longint lo, logic [63:0] u);
		longint      d;
		logic [63:0] ad;
		logic [63:0] q;
		d = hi - lo;
		ad = d < 0 ? 64'(-d) : 64'(d);
		q = ad * (u >> 31) + ((ad * (u & 64'h7FFF_FFFF)) >> 31);
		if (q > (64'd1 << 40)) q = 64'd1 << 40;
		return d < 0 ? base - longint'(q) : base + longint'(q);
	endfunction

	function automatic curve_result_t log_blend(logic [31:0] f1, logic [31:0] f2, bit extrap,
			logic [63:0] u);
		curve_result_t r;
		longint        l1;
		longint        l2;
		bit            sat;
		if (f1 == 0 || f2 == 0) begin
			r.factor = '0;
			r.status = dci_pkg::STAT_ZERO_FACTOR;
			return r;
		end
		l1 = log2_q(f1);
		l2 = log2_q(f2);
		r.factor = exp2_q(extrap ? log_step(l2, l2, l1, u) : log_step(l1, l2, l1, u), sat);
		r.status = sat ? dci_pkg::STAT_SATURATED : dci_pkg::STAT_OK;
		return r;
	endfunction

	function automatic curve_result_t discount_at(logic [31:0] t);
		curve_result_t r;
		int            n;
		int            lo;
		int            cnt;
		int            stp;
		int            i;
		logic [31:0]   t1;
		logic [31:0]   t2;
		logic [31:0]   num;
		logic [31:0]   den;
		logic [63:0]   w;
		n = curve_count > KNOTS ? KNOTS : curve_count;
		r.status = dci_pkg::STAT_OK;
		if (n == 0) begin
			r.factor = '0;
			r.status = dci_pkg::STAT_EMPTY;
			return r;
		end
		if (n == 1 || t <= knot_time[0]) begin
			r.factor = knot_fac[0];
			return r;
		end
		if (t >= knot_time[n - 1]) begin
			if (curve_mode != dci_pkg::MODE_FLAT_FWD || t == knot_time[n - 1]) begin
				r.factor = knot_fac[n - 1];
				return r;
			end
			t1 = knot_time[n - 2];
			t2 = knot_time[n - 1];
			if (t2 <= t1) begin
				r.factor = knot_fac[n - 1];
				r.status = dci_pkg::STAT_ZERO_WIDTH;
				return r;
			end
			w = (64'(t - t2) << 31) / 64'(t2 - t1);
			return log_blend(knot_fac[n - 2], knot_fac[n - 1], 1, w);
		end
		// Lower-bound search for the first knot not below t.
		lo = 0;
		cnt = n;
		while (cnt > 0) begin
			stp = cnt / 2;
			if (knot_time[lo + stp] < t) begin
				lo = lo + stp + 1;
				cnt = cnt - stp - 1;
			end else begin
				cnt = stp;
			end
		end
		i = lo > 0 ? lo - 1 : 0;
		if (i > n - 2) i = n - 2;
		t1 = knot_time[i];
		t2 = knot_time[i + 1];
		if (t2 <= t1) begin
			r.factor = knot_fac[i];
			r.status = dci_pkg::STAT_ZERO_WIDTH;
			return r;
		end
		den = t2 - t1;
		num = t > t1 ? t - t1 : 32'd0;
		w = num >= den ? 64'h8000_0000 : (64'(num) << 31) / 64'(den);
		if (curve_mode == dci_pkg::MODE_LOG_LINEAR || curve_mode == dci_pkg::MODE_FLAT_FWD)
			return log_blend(knot_fac[i], knot_fac[i + 1], 0, w);
		if (knot_fac[i + 1] >= knot_fac[i])
			r.factor = knot_fac[i] + 32'((64'(knot_fac[i + 1] - knot_fac[i]) * w) >> 31);
		else
			r.factor = knot_fac[i] - 32'((64'(knot_fac[i] - knot_fac[i + 1]) * w) >> 31);
		return r;
	endfunction

	// Offers one request after a random gap (none while no_idle is set) and waits for it to be taken.
	task automatic send_request(logic cmd, logic [4:0] idx, logic [31:0] tp, logic [31:0] fac);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {3'b000, fac, tp, idx};
		do @(posedge clk); while (!s_tready);
		sent++;
		if (cmd == dci_pkg::CMD_LOAD) begin
			knot_time[idx] = tp;
			knot_fac[idx] = fac;
		end else begin
			pending_factors.push_back(discount_at(tp));
		end
	endtask

	task automatic query(logic [31:0] tp);
		send_request(dci_pkg::CMD_QUERY, 5'($urandom), tp, $urandom);
	endtask

	// Waits until every result is back and the core has gone quiet.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_factors.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] value);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == dci_pkg::ADDR_MODE) curve_mode = value[1:0];
		else curve_count = value[5:0];
	endtask

	task automatic set_curve(logic [1:0] m, logic [5:0] n);
		reg_write(dci_pkg::ADDR_MODE, 32'(m));
		reg_write(dci_pkg::ADDR_COUNT, 32'(n));
	endtask

	// Result side: random stalls, an occasional long hold-off, and the comparison.
	initial begin
		curve_result_t want;
		int            stall;
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 8);
			if (hold_req) begin
				stall = 3000;
				hold_req = 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (pending_factors.size() == 0) begin
				$display("%0t: unexpected result factor %h status %0d", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = pending_factors.pop_front();
				if (m_tdata !== want.factor) begin
					$display("%0t: factor expected %h actual %h", $time, want.factor, m_tdata);
					errors++;
				end
				if (m_tuser !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						m_tuser);
					errors++;
				end
			end
		end
	end

	// An empty table must answer every query with the empty status.
	task automatic test_empty_table();
		query(32'h0);
		query(32'hFFFF_FFFF);
	endtask

	// Loads every slot with a gently falling curve, one knot per year.
	task automatic test_load_all();
		for (int i = 0; i < KNOTS; i++)
			send_request(dci_pkg::CMD_LOAD, 5'(i), 32'((i + 1) << 16),
				32'h4000_0000 - 32'(i) * 32'h0100_0000);
	endtask

	task automatic test_directed();
		set_curve(dci_pkg::MODE_LINEAR, 6'd1);
		query(32'h0003_0000);
		set_curve(dci_pkg::MODE_LINEAR, 6'd32);
		query(32'h0);
		query(32'h0001_0000);
		query(32'h0001_8000);
		query(32'h0020_0000);
		query(32'hFFFF_FFFF);
		set_curve(dci_pkg::MODE_LOG_LINEAR, 6'd63);
		query(32'h0005_4000);
		query(32'h0030_0000);
		set_curve(dci_pkg::MODE_FLAT_FWD, 6'd32);
		query(32'h0010_8000);
		query(32'h0020_0000);
		query(32'h0028_0000);
		set_curve(2'd3, 6'd32);
		query(32'h0007_C000);
		// Zero factor inside the table in a log mode.
		send_request(dci_pkg::CMD_LOAD, 5'd1, 32'h0002_0000, 32'h0);
		set_curve(dci_pkg::MODE_LOG_LINEAR, 6'd3);
		query(32'h0001_8000);
		// A last interval of zero width while extrapolating.
		send_request(dci_pkg::CMD_LOAD, 5'd1, 32'h0003_0000, 32'h3000_0000);
		send_request(dci_pkg::CMD_LOAD, 5'd2, 32'h0003_0000, 32'h2000_0000);
		set_curve(dci_pkg::MODE_FLAT_FWD, 6'd3);
		query(32'h0004_0000);
		// A rising curve extrapolated far enough to saturate, and a falling one to underflow.
		send_request(dci_pkg::CMD_LOAD, 5'd0, 32'h0001_0000, 32'h4000_0000);
		send_request(dci_pkg::CMD_LOAD, 5'd1, 32'h0002_0000, 32'hC000_0000);
		set_curve(dci_pkg::MODE_FLAT_FWD, 6'd2);
		query(32'h000A_0000);
		send_request(dci_pkg::CMD_LOAD, 5'd1, 32'h0002_0000, 32'h0000_0100);
		query(32'h0100_0000);
	endtask

	// Refills the table: mostly sorted curves, sometimes with repeated times or zero factors,
	// and sometimes arbitrary values.
	task automatic load_random_curve(int n);
		int          kind;
		logic [31:0] t;
		logic [31:0] f;
		kind = $urandom_range(0, 5);
		t = $urandom_range(0, 32'h0004_0000);
		f = $urandom_range(32'h3000_0000, 32'h5000_0000);
		if (kind == 5) t = $urandom;
		for (int i = 0; i < n; i++) begin
			if (kind == 4) begin
				send_request(dci_pkg::CMD_LOAD, 5'(i), $urandom, $urandom);
			end else begin
				send_request(dci_pkg::CMD_LOAD, 5'(i), t,
					($urandom_range(0, 15) == 0 && kind == 3) ? 32'h0 : f);
				if (!(kind == 3 && $urandom_range(0, 3) == 0))
					t = t + $urandom_range(1, kind == 5 ? 32'h0800_0000 : 32'h0008_0000);
				f = kind == 2 ? f + $urandom_range(0, f >> 3) : f - $urandom_range(0, f >> 4);
			end
		end
	endtask

	task automatic random_query(int n);
		int          k;
		logic [31:0] lo;
		logic [31:0] hi;
		lo = knot_time[0];
		hi = knot_time[(n > 1 ? n : 2) - 1];
		case ($urandom_range(0, 9))
			0: query($urandom);
			1: query(knot_time[$urandom_range(0, KNOTS - 1)]);
			2: query(hi + $urandom_range(0, 32'h0100_0000));
			default: begin
				k = $urandom_range(0, 31);
				if (hi > lo) query(lo - 32'h100 + 32'((64'(hi - lo) * k) / 28) + $urandom_range(0, 255));
				else query($urandom);
			end
		endcase
	endtask

	task automatic test_random_curves();
		logic [1:0] m;
		int         n;
		int         queries;
		while (sent < 1350) begin
			m = $urandom_range(0, 3);
			case ($urandom_range(0, 5))
				0: n = 32;
				1: n = $urandom_range(0, 2);
				2: n = $urandom_range(33, 63);
				default: n = $urandom_range(3, 31);
			endcase
			no_idle = $urandom_range(0, 4) == 0;
			load_random_curve(n > KNOTS ? KNOTS : n);
			set_curve(m, 6'(n));
			queries = $urandom_range(30, 90);
			for (int q = 0; q < queries; q++) random_query(n > KNOTS ? KNOTS : n);
			no_idle = 0;
		end
	endtask

	// The result side holds off while queries keep coming, so the core backs up its input.
	task automatic test_backpressure();
		set_curve(dci_pkg::MODE_LOG_LINEAR, 6'd32);
		hold_req = 1;
		for (int q = 0; q < 8; q++) random_query(KNOTS);
	endtask

	initial begin
		logic [63:0] r;
		r = 64'h1_0000_0000;
		for (int k = 0; k < LOG_BITS; k++) begin
			r = int_sqrt(r << 31);
			exp_root[k] = r;
		end
		curve_mode = dci_pkg::MODE_LINEAR;
		curve_count = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_load_all();
		test_directed();
		test_backpressure();
		test_random_curves();
		settle();
		if (errors == 0 && pending_factors.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- discount_curve_interpolator_core.f -----
design/dci_pkg.sv
design/dci_ctrl.sv
design/dci_datapath.sv
design/discount_curve_interpolator_core.sv
verif/tb.sv
